@@ design/assert_macros.svh @@
// assertion macros used by the checker file btda_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BTDA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define BTDA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/btda_pkg.sv @@
`default_nettype none

package btda_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_W           = 32;
    localparam int CHAR_W         = 8;
    localparam int LEN_W          = 4;
    localparam int DIGIT_W        = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // decimal digits needed for the largest unsigned value of the given width
    function automatic int digits_for(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    typedef struct packed {
        logic load;
        logic bin_shift;
        logic dig_shift;
    } t_dab_ctl;

endpackage

`default_nettype wire

@@ design/btda_dabble.sv @@
`default_nettype none

module btda_dabble #(
    parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire btda_pkg::t_dab_ctl           i_ctl,
    input  wire logic [VALUE_BITS-1:0]        i_mag,
    output logic      [btda_pkg::DIGIT_W-1:0] o_top_digit
);
    import btda_pkg::*;

    localparam int NDIG  = digits_for(VALUE_BITS);
    localparam int BCD_W = NDIG * DIGIT_W;

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      w_adj;

    // add 3 to every digit of 5 or more before the next doubling
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                w_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                w_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (i_ctl.bin_shift) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
        end else if (i_ctl.dig_shift) begin
            r_bcd <= {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

@@ design/binary_to_decimal_ascii.sv @@
// the first character follows start after the double dabble loop and the leading zero skip
// a new transaction is accepted only in idle, which the block reaches with the last character
// the double dabble loop takes one bit per cycle, and the zero skip and emission
// take one digit per cycle
// characters follow back to back, one per cycle; the receiver cannot stall them
// synchronous active-low reset returns to idle and drops the strobe
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = btda_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_action,
    input  wire logic [btda_pkg::IN_W-1:0]   i_value,
    output logic                             o_strobe,
    output logic      [btda_pkg::CHAR_W-1:0] o_character,
    output logic      [btda_pkg::LEN_W-1:0]  o_text_length,
    output logic                             o_last
);
    import btda_pkg::*;

    localparam int NDIG  = digits_for(VALUE_BITS);
    localparam int BIT_W = $clog2(VALUE_BITS);
    localparam int CNT_W = $clog2(NDIG + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [BIT_W-1:0]      r_bitcnt, n_bitcnt;
    logic [CNT_W-1:0]      r_ndig, n_ndig;
    logic                  r_neg, n_neg;
    logic [LEN_W-1:0]      r_len, n_len;
    logic                  n_strobe, n_last;
    logic [CHAR_W-1:0]     n_character;
    logic [LEN_W-1:0]      n_text_length;

    logic [VALUE_BITS-1:0] w_word, w_mag;
    logic                  w_neg;
    logic [CNT_W:0]        w_total;
    logic [DIGIT_W-1:0]    w_top;
    t_dab_ctl              w_ctl;

    assign w_word  = VALUE_BITS'(i_value);
    assign w_neg   = i_action & w_word[VALUE_BITS-1];
    assign w_mag   = w_neg ? (~w_word + 1'b1) : w_word;
    assign w_total = {1'b0, r_ndig} + (CNT_W+1)'(r_neg);
    assign busy    = (r_state != S_IDLE);

    btda_dabble #(.VALUE_BITS(VALUE_BITS)) u_dabble (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    always_comb begin
        n_state       = r_state;
        n_bitcnt      = r_bitcnt;
        n_ndig        = r_ndig;
        n_neg         = r_neg;
        n_len         = r_len;
        n_strobe      = 1'b0;
        n_last        = 1'b0;
        n_character   = o_character;
        n_text_length = o_text_length;
        w_ctl         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_ctl.load = 1'b1;
                    n_neg      = w_neg;
                    n_bitcnt   = BIT_W'(VALUE_BITS - 1);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                w_ctl.bin_shift = 1'b1;
                n_bitcnt        = r_bitcnt - 1'b1;
                if (r_bitcnt == '0) begin
                    n_ndig  = CNT_W'(NDIG);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (w_top == '0 && r_ndig > CNT_W'(1)) begin
                    w_ctl.dig_shift = 1'b1;
                    n_ndig          = r_ndig - 1'b1;
                end else begin
                    n_len   = LEN_W'(w_total);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_strobe      = 1'b1;
                n_text_length = r_len;
                if (r_neg) begin
                    n_character = ASCII_MINUS;
                    n_neg       = 1'b0;
                end else begin
                    n_character     = ASCII_ZERO + CHAR_W'(w_top);
                    w_ctl.dig_shift = 1'b1;
                    n_ndig          = r_ndig - 1'b1;
                    if (r_ndig == CNT_W'(1)) begin
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bitcnt      <= n_bitcnt;
        r_ndig        <= n_ndig;
        r_neg         <= n_neg;
        r_len         <= n_len;
        o_last        <= n_last;
        o_character   <= n_character;
        o_text_length <= n_text_length;
    end

endmodule

`default_nettype wire

@@ design/btda_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module btda_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_strobe,
    input wire logic [btda_pkg::CHAR_W-1:0] o_character,
    input wire logic [btda_pkg::LEN_W-1:0]  o_text_length,
    input wire logic                        o_last
);
    // a transaction makes the block busy
    `BTDA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // characters of one run come back to back with one length
    `BTDA_ASSERT_NEXT(a_run_cont, i_clk, i_rst_n, o_strobe && !o_last, o_strobe && $stable(o_text_length))
    // the block stays busy until the final character
    `BTDA_ASSERT_NOW(a_busy_mid, i_clk, i_rst_n, o_strobe && !o_last, busy)
    `BTDA_ASSERT_NOW(a_idle_end, i_clk, i_rst_n, o_strobe && o_last, !busy)
    // only minus or a decimal digit is emitted
    `BTDA_ASSERT_NOW(a_char_set, i_clk, i_rst_n, o_strobe, (o_character == 8'd45) || ((o_character >= 8'd48) && (o_character <= 8'd57)))

endmodule

bind binary_to_decimal_ascii btda_checker u_btda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_character   (o_character),
    .o_text_length (o_text_length),
    .o_last        (o_last)
);

`default_nettype wire

@@ tb/sv/binary_to_decimal_ascii_test.sv @@
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;

    localparam logic MODE_UNSIGNED  = 1'b0;
    localparam logic MODE_SIGNED    = 1'b1;
    localparam int   NUM_CASES      = 18;
    localparam int   RANDOM_ITEMS   = 480;
    localparam int   QUIET_FIRST    = 200;
    localparam int   QUIET_LAST     = 330;
    localparam int   MAX_GAP        = 60;
    localparam int   DRAIN_CYCLES   = 60;
    localparam int   WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [btda_pkg::CHAR_W-1:0] ch;
        logic [btda_pkg::LEN_W-1:0]  len;
        logic                        last;
    } t_text_char;

    logic                        i_clk    = 1'b0;
    logic                        i_rst_n  = 1'b0;
    logic                        start    = 1'b0;
    logic                        i_action = 1'b0;
    logic [btda_pkg::IN_W-1:0]   i_value  = '0;
    logic                        busy;
    logic                        o_strobe;
    logic [btda_pkg::CHAR_W-1:0] o_character;
    logic [btda_pkg::LEN_W-1:0]  o_text_length;
    logic                        o_last;

    t_text_char expected_chars[$];
    t_text_char want;
    int         cur_case      = -1;
    int         errors        = 0;
    int         items_taken   = 0;
    int         negatives     = 0;
    int         chars_checked = 0;
    int         quiet_cycles  = 0;

    // mode and word of each directed row, with its text where it is obvious
    logic [32:0] case_item [NUM_CASES] = '{
        {MODE_UNSIGNED, 32'd0},
        {MODE_SIGNED,   32'd0},
        {MODE_UNSIGNED, 32'd9},
        {MODE_UNSIGNED, 32'd10},
        {MODE_UNSIGNED, 32'hFFFF_FFFF},
        {MODE_SIGNED,   32'hFFFF_FFFF},
        {MODE_SIGNED,   32'h8000_0000},
        {MODE_UNSIGNED, 32'h8000_0000},
        {MODE_SIGNED,   32'h7FFF_FFFF},
        {MODE_SIGNED,   32'hFFFF_FFF6},
        {MODE_SIGNED,   32'hFFFF_FF9C},
        {MODE_UNSIGNED, 32'd1000000000},
        {MODE_SIGNED,   32'd5},
        {MODE_UNSIGNED, 32'd999999999},
        {MODE_SIGNED,   32'h8000_0001},
        {MODE_UNSIGNED, 32'h5555_5555},
        {MODE_SIGNED,   32'hAAAA_AAAA},
        {MODE_UNSIGNED, 32'd12345}
    };

    string case_text [NUM_CASES] = '{
        "0", "0", "9", "10", "4294967295", "-1", "-2147483648", "2147483648",
        "2147483647", "-10", "-100", "1000000000", "5", "", "", "", "", ""
    };

    logic [31:0] pow10 [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
        32'd10000000, 32'd100000000, 32'd1000000000
    };

    binary_to_decimal_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_character   (o_character),
        .o_text_length (o_text_length),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void push_text(input string s);
        t_text_char c;
        for (int i = 0; i < s.len(); i++) begin
            c.ch   = s[i];
            c.len  = 4'(s.len());
            c.last = (i == s.len() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic void predict_text(input logic sgn, input logic [31:0] word);
        logic [31:0] mag;
        logic [3:0]  digs [10];
        logic        neg;
        int          nd;
        int          total;
        t_text_char  c;
        neg = (sgn == MODE_SIGNED) && word[31];
        mag = neg ? -word : word;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end while (mag != 0);
        total = nd + (neg ? 1 : 0);
        if (neg) begin
            c.ch   = btda_pkg::ASCII_MINUS;
            c.len  = 4'(total);
            c.last = (total == 1);
            expected_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.ch   = btda_pkg::ASCII_ZERO + 8'(digs[i]);
            c.len  = 4'(total);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        int          k;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = $urandom;
            4, 5:       w = $urandom % pow10[k];
            6:          w = -32'($urandom_range(1, 1000));
            7:          w = pow10[k] + 32'($urandom_range(0, 2)) - 32'd1;
            8: begin
                case ($urandom_range(0, 4))
                    0:       w = 32'd0;
                    1:       w = 32'h8000_0000;
                    2:       w = 32'h7FFF_FFFF;
                    3:       w = 32'hFFFF_FFFF;
                    default: w = 32'h8000_0001;
                endcase
            end
            default:    w = $urandom >> $urandom_range(0, 31);
        endcase
        return w;
    endfunction

    // called at the edge that took the previous transaction, or after reset
    task automatic send_item(input int n, input int row, input logic sgn,
                             input logic [31:0] word);
        int gap;
        gap = 0;
        if ((n < QUIET_FIRST || n >= QUIET_LAST) && $urandom_range(0, 99) < 19)
            gap = $urandom_range(1, MAX_GAP);
        if (gap > 0) begin
            start    <= 1'b0;
            i_action <= $urandom_range(0, 1);
            i_value  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= sgn;
        i_value  <= word;
        cur_case <= row;
        do @(posedge i_clk); while (busy);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected character %0d length %0d last %0b", $time,
                             o_character, o_text_length, o_last);
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (o_character !== want.ch || o_text_length !== want.len ||
                        o_last !== want.last) begin
                        errors++;
                        $display("%0t: expected char %0d len %0d last %0b, got %0d %0d %0b",
                                 $time, want.ch, want.len, want.last,
                                 o_character, o_text_length, o_last);
                    end
                end
            end
            if (start && !busy) begin
                items_taken++;
                if (i_action == MODE_SIGNED && i_value[31])
                    negatives++;
                if (cur_case >= 0 && case_text[cur_case].len() > 0)
                    push_text(case_text[cur_case]);
                else
                    predict_text(i_action, i_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int r = 0; r < NUM_CASES; r++)
            send_item(r, r, case_item[r][32], case_item[r][31:0]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(n, -1, $urandom_range(0, 1), pick_word());
        start <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            errors++;
            $display("%0t: expected %0d more characters, got 0", $time,
                     expected_chars.size());
        end
        $display("converted %0d words (%0d negative), %0d characters compared, %0d errors",
                 items_taken, negatives, chars_checked, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
